[rtl/ogs_pkg.sv]
// Shared types and genotype codes for the offspring genotype sampler.
package ogs_pkg;

    localparam int W_BITS = 16;
    localparam int SUM_BITS = W_BITS + 2;

    localparam logic [1:0] G_HOM_REF = 2'd0;
    localparam logic [1:0] G_HET     = 2'd1;
    localparam logic [1:0] G_HOM_ALT = 2'd2;
    localparam logic [1:0] G_MISSING = 2'd3;

    typedef struct packed {
        logic ok;
        logic allele;
    } t_pat_res;

endpackage

[rtl/ogs_in_if.sv]
// Input item channel of the offspring genotype sampler.
interface ogs_in_if #(
    parameter int PROB_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic                 start_of_offspring;
    logic [1:0]           mom_genotype;
    logic                 phase_bit;
    logic [PROB_BITS-1:0] recomb_rate;
    logic [15:0]          weight_hom_ref;
    logic [15:0]          weight_het;
    logic [15:0]          weight_hom_alt;
    logic [PROB_BITS-1:0] draw_path;
    logic [PROB_BITS-1:0] draw_paternal;
    logic [PROB_BITS-1:0] draw_het_coin;
    logic [PROB_BITS-1:0] draw_error;
    logic [PROB_BITS-1:0] draw_error_pick;

    modport source (
        output valid, start_of_offspring, mom_genotype, phase_bit, recomb_rate,
               weight_hom_ref, weight_het, weight_hom_alt, draw_path, draw_paternal,
               draw_het_coin, draw_error, draw_error_pick,
        input  ready
    );
    modport sink (
        input  valid, start_of_offspring, mom_genotype, phase_bit, recomb_rate,
               weight_hom_ref, weight_het, weight_hom_alt, draw_path, draw_paternal,
               draw_het_coin, draw_error, draw_error_pick,
        output ready
    );
endinterface

[rtl/ogs_out_if.sv]
// Result item channel of the offspring genotype sampler.
interface ogs_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] genotype;
    logic       path_bit;

    modport source (output valid, genotype, path_bit, input ready);
    modport sink (input valid, genotype, path_bit, output ready);
endinterface

[rtl/ogs_cfg_if.sv]
// Configuration write channel carrying the error rate register.
interface ogs_cfg_if #(
    parameter int PROB_BITS = 16
);
    logic               valid;
    logic               ready;
    logic [PROB_BITS:0] err_prob;

    modport source (output valid, err_prob, input ready);
    modport sink (input valid, err_prob, output ready);
endinterface

[rtl/offspring_genotype_sampler.sv]
// Top level: input register, genotype sampling logic and result register.
// Path: an accepted input item is held in the input register and moves on to
// the result register when that register is free or being read.
// Throughput: one item per cycle while o_out.ready is high; the haplotype bit
// recurrence closes in the compute stage between input and result register.
// Reset: synchronous active-low i_rst_n clears both stage valids, the
// haplotype bit and the error rate register.
module offspring_genotype_sampler
    import ogs_pkg::*;
#(
    parameter int PROB_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ogs_in_if.sink   i_in,
    ogs_cfg_if.sink  i_cfg,
    ogs_out_if.source o_out
);
    logic                 r_s1_valid;
    logic                 r_s1_start;
    logic [1:0]           r_s1_mom;
    logic                 r_s1_phase;
    logic [PROB_BITS-1:0] r_s1_rate;
    logic [W_BITS-1:0]    r_s1_w0;
    logic [W_BITS-1:0]    r_s1_w1;
    logic [W_BITS-1:0]    r_s1_w2;
    logic [PROB_BITS-1:0] r_s1_d_path;
    logic [PROB_BITS-1:0] r_s1_d_pat;
    logic [PROB_BITS-1:0] r_s1_d_coin;
    logic [PROB_BITS-1:0] r_s1_d_err;
    logic [PROB_BITS-1:0] r_s1_d_pick;

    logic                 r_hap;
    logic [PROB_BITS:0]   r_err_rate;
    logic                 r_out_valid;
    logic [1:0]           r_out_genotype;
    logic                 r_out_path;

    logic                 out_free;
    logic                 s1_go;
    logic                 in_take;
    logic                 n_hap;
    logic                 a_mom;
    logic [1:0]           y_sum;
    logic                 err_hit;
    logic [1:0]           n_genotype;
    t_pat_res             pat;

    assign out_free   = ~r_out_valid | o_out.ready;
    assign s1_go      = r_s1_valid & out_free;
    assign i_in.ready = ~r_s1_valid | out_free;
    assign in_take    = i_in.valid & i_in.ready;
    assign i_cfg.ready = 1'b1;

    ogs_path #(.PROB_BITS(PROB_BITS)) u_path (
        .i_hap   (r_hap),
        .i_start (r_s1_start),
        .i_rate  (r_s1_rate),
        .i_draw  (r_s1_d_path),
        .o_hap   (n_hap)
    );

    ogs_paternal #(.PROB_BITS(PROB_BITS)) u_paternal (
        .i_w0   (r_s1_w0),
        .i_w1   (r_s1_w1),
        .i_w2   (r_s1_w2),
        .i_draw (r_s1_d_pat),
        .i_coin (r_s1_d_coin),
        .o_res  (pat)
    );

    always_comb begin
        case (r_s1_mom)
            G_HOM_REF: a_mom = 1'b0;
            G_HOM_ALT: a_mom = 1'b1;
            default:   a_mom = n_hap ^ r_s1_phase;
        endcase
        y_sum   = {1'b0, a_mom} + {1'b0, pat.allele};
        err_hit = {1'b0, r_s1_d_err} < r_err_rate;
        n_genotype = y_sum;
        // replace with one of the two other genotypes
        if (err_hit) begin
            case (y_sum)
                G_HOM_REF: n_genotype = r_s1_d_pick[PROB_BITS-1] ? G_HOM_ALT : G_HET;
                G_HET:     n_genotype = r_s1_d_pick[PROB_BITS-1] ? G_HOM_ALT : G_HOM_REF;
                default:   n_genotype = r_s1_d_pick[PROB_BITS-1] ? G_HET : G_HOM_REF;
            endcase
        end
        if (r_s1_mom == G_MISSING || !pat.ok) begin
            n_genotype = G_MISSING;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_hap       <= 1'b0;
            r_err_rate  <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_err_rate <= i_cfg.err_prob;
            end
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_out_valid <= 1'b1;
                r_hap       <= n_hap;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_start  <= i_in.start_of_offspring;
            r_s1_mom    <= i_in.mom_genotype;
            r_s1_phase  <= i_in.phase_bit;
            r_s1_rate   <= i_in.recomb_rate;
            r_s1_w0     <= i_in.weight_hom_ref;
            r_s1_w1     <= i_in.weight_het;
            r_s1_w2     <= i_in.weight_hom_alt;
            r_s1_d_path <= i_in.draw_path;
            r_s1_d_pat  <= i_in.draw_paternal;
            r_s1_d_coin <= i_in.draw_het_coin;
            r_s1_d_err  <= i_in.draw_error;
            r_s1_d_pick <= i_in.draw_error_pick;
        end
        if (s1_go) begin
            r_out_genotype <= n_genotype;
            r_out_path     <= n_hap;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.genotype = r_out_genotype;
    assign o_out.path_bit = r_out_path;

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_s1_valid && r_out_valid && !o_out.ready))
        else $error("input stalled while a stage is free");

    a_start_coin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_s1_start) |=> (r_hap == $past(r_s1_d_path[PROB_BITS-1])))
        else $error("haplotype bit at a new offspring does not follow the coin");

    a_hap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_go |=> (r_hap == $past(r_hap)))
        else $error("haplotype bit changed without an item moving");

    a_path_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go |=> (r_out_path == r_hap))
        else $error("reported path bit differs from the kept haplotype bit");
endmodule

[rtl/ogs_path.sv]
// Next maternal haplotype bit: fair coin at a new offspring, clamped flip otherwise.
module ogs_path #(
    parameter int PROB_BITS = 16
) (
    input  logic                 i_hap,
    input  logic                 i_start,
    input  logic [PROB_BITS-1:0] i_rate,
    input  logic [PROB_BITS-1:0] i_draw,
    output logic                 o_hap
);
    localparam logic [PROB_BITS-1:0] RATE_MAX =
        PROB_BITS'((64'd49 * (64'd1 << PROB_BITS)) / 64'd100);
    localparam logic [PROB_BITS-1:0] RATE_MIN = PROB_BITS'(1);

    logic [PROB_BITS-1:0] rate_c;

    always_comb begin
        if (i_rate > RATE_MAX) begin
            rate_c = RATE_MAX;
        end else if (i_rate < RATE_MIN) begin
            rate_c = RATE_MIN;
        end else begin
            rate_c = i_rate;
        end
    end

    // draw below one half picks haplotype 0
    assign o_hap = i_start ? i_draw[PROB_BITS-1] : (i_hap ^ (i_draw < rate_c));
endmodule

[rtl/ogs_paternal.sv]
// Paternal allele draw by cross-multiplying the draw with the weight sum.
module ogs_paternal
    import ogs_pkg::*;
#(
    parameter int PROB_BITS = 16
) (
    input  logic [W_BITS-1:0]    i_w0,
    input  logic [W_BITS-1:0]    i_w1,
    input  logic [W_BITS-1:0]    i_w2,
    input  logic [PROB_BITS-1:0] i_draw,
    input  logic [PROB_BITS-1:0] i_coin,
    output t_pat_res             o_res
);
    localparam int PW = PROB_BITS + SUM_BITS;

    logic [SUM_BITS-1:0] sum;
    logic [W_BITS:0]     w01;
    logic [PW-1:0]       prod;
    logic [PW-1:0]       lim0;
    logic [PW-1:0]       lim1;

    assign sum  = SUM_BITS'(i_w0) + SUM_BITS'(i_w1) + SUM_BITS'(i_w2);
    assign w01  = (W_BITS+1)'(i_w0) + (W_BITS+1)'(i_w1);
    assign prod = PW'(i_draw) * PW'(sum);
    assign lim0 = PW'({i_w0, {PROB_BITS{1'b0}}});
    assign lim1 = PW'({w01, {PROB_BITS{1'b0}}});

    always_comb begin
        o_res.ok = (sum != '0);
        if (prod < lim0) begin
            o_res.allele = 1'b1;
        end else if (prod < lim1) begin
            o_res.allele = ~i_coin[PROB_BITS-1];
        end else begin
            o_res.allele = 1'b0;
        end
    end
endmodule
